/* hdl/b64d_pkg.sv */
// shared types, constants and the character lookup for the base64 stream decoder
// no dependencies; used by every module of the decoder
package b64d_pkg;

    localparam int OUT_BYTES = 64;                       // size of one output pattern
    localparam int BW_W      = $clog2(OUT_BYTES + 1);    // bytes written, saturates at OUT_BYTES
    localparam int IDX_W     = 6;
    localparam int VAL_W     = 7;                        // six-bit value plus invalid flag
    localparam int NUM_SLOTS = 3;                        // bytes per group at most
    localparam int CNT_W     = 2;

    localparam logic [VAL_W-1:0] BAD_VALUE  = 7'h7F;
    localparam logic [7:0]       CH_UPPER_A = 8'h41;
    localparam logic [7:0]       CH_UPPER_Z = 8'h5A;
    localparam logic [7:0]       CH_LOWER_A = 8'h61;
    localparam logic [7:0]       CH_LOWER_Z = 8'h7A;
    localparam logic [7:0]       CH_DIGIT_0 = 8'h30;
    localparam logic [7:0]       CH_DIGIT_9 = 8'h39;
    localparam logic [7:0]       CH_PLUS    = 8'h2B;
    localparam logic [7:0]       CH_SLASH   = 8'h2F;
    localparam logic [VAL_W-1:0] VAL_PLUS   = 7'd62;
    localparam logic [VAL_W-1:0] VAL_SLASH  = 7'd63;
    localparam logic [VAL_W-1:0] OFS_LOWER  = 7'd26;
    localparam logic [VAL_W-1:0] OFS_DIGIT  = 7'd52;

    typedef struct packed {
        logic [7:0]       data;
        logic [IDX_W-1:0] index;
        logic             bvalid;
        logic             done;
    } result_t;

    typedef struct packed {
        logic [CNT_W-1:0]          cnt;
        result_t [NUM_SLOTS-1:0]   slot;
    } group_res_t;

    // standard alphabet, anything else maps to the invalid value
    function automatic logic [VAL_W-1:0] char_value(input logic [7:0] ch);
        logic [VAL_W-1:0] v;
        v = BAD_VALUE;
        if (ch inside {[CH_UPPER_A:CH_UPPER_Z]})
        begin
            v = VAL_W'(ch - CH_UPPER_A);
        end
        else if (ch inside {[CH_LOWER_A:CH_LOWER_Z]})
        begin
            v = VAL_W'(ch - CH_LOWER_A) + OFS_LOWER;
        end
        else if (ch inside {[CH_DIGIT_0:CH_DIGIT_9]})
        begin
            v = VAL_W'(ch - CH_DIGIT_0) + OFS_DIGIT;
        end
        else if (ch == CH_PLUS)
        begin
            v = VAL_PLUS;
        end
        else if (ch == CH_SLASH)
        begin
            v = VAL_SLASH;
        end
        return v;
    endfunction

endpackage

/* hdl/b64d_group.sv */
// group state and decode: holds up to three values, decodes a completed group
// into up to three result words; depends on b64d_pkg
module b64d_group (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [7:0]            text_char,
    input  logic                  end_of_text,
    output logic                  completes,
    output b64d_pkg::group_res_t  res
);

    logic [1:0]                     pos_reg, pos_next;
    logic [b64d_pkg::VAL_W-1:0]     held_reg [3];
    logic [b64d_pkg::VAL_W-1:0]     held_next [3];
    logic [b64d_pkg::BW_W-1:0]      bw_reg, bw_next;
    logic                           halted_reg, halted_next;

    logic [b64d_pkg::VAL_W-1:0]     v;
    logic [b64d_pkg::VAL_W-1:0]     vals [4];
    logic                           bad_ab;
    logic [7:0]                     cb [3];
    logic [2:0]                     en;
    logic [b64d_pkg::BW_W-1:0]      bw_t;
    logic [b64d_pkg::CNT_W-1:0]     n;

    always_comb
    begin
        v         = b64d_pkg::char_value(text_char);
        completes = (pos_reg == 2'd3) || end_of_text;

        // missing positions of a short last group read as zero
        vals[0] = (pos_reg == 2'd0) ? v : held_reg[0];
        vals[1] = (pos_reg > 2'd1) ? held_reg[1] : ((pos_reg == 2'd1) ? v : '0);
        vals[2] = (pos_reg > 2'd2) ? held_reg[2] : ((pos_reg == 2'd2) ? v : '0);
        vals[3] = (pos_reg == 2'd3) ? v : '0;

        bad_ab = vals[0][6] | vals[1][6];

        cb[0] = {vals[0][5:0], vals[1][5:4]};
        cb[1] = {vals[1][3:0], vals[2][5:2]};
        cb[2] = {vals[2][1:0], vals[3][5:0]};

        en[0] = !halted_reg && !bad_ab;
        en[1] = en[0] && !vals[2][6];
        en[2] = en[0] && !vals[3][6];

        // pack enabled bytes in order, stopping when the pattern is full
        res  = '0;
        n    = '0;
        bw_t = bw_reg;
        for (int i = 0; i < b64d_pkg::NUM_SLOTS; i++)
        begin
            if (en[i] && (bw_t < b64d_pkg::BW_W'(b64d_pkg::OUT_BYTES)))
            begin
                res.slot[n].data   = cb[i];
                res.slot[n].index  = b64d_pkg::IDX_W'(bw_t);
                res.slot[n].bvalid = 1'b1;
                res.slot[n].done   = 1'b0;
                n    = n + b64d_pkg::CNT_W'(1);
                bw_t = bw_t + b64d_pkg::BW_W'(1);
            end
        end

        if (end_of_text)
        begin
            if (n == '0)
            begin
                // bare end marker
                res.slot[0].done = 1'b1;
                n = b64d_pkg::CNT_W'(1);
            end
            else
            begin
                res.slot[n - b64d_pkg::CNT_W'(1)].done = 1'b1;
            end
        end
        res.cnt = n;
    end

    always_comb
    begin
        pos_next    = pos_reg;
        held_next   = held_reg;
        bw_next     = bw_reg;
        halted_next = halted_reg;
        if (step)
        begin
            if (!completes)
            begin
                held_next[pos_reg] = v;
                pos_next           = pos_reg + 2'd1;
            end
            else if (end_of_text)
            begin
                pos_next    = '0;
                held_next   = '{default: '0};
                bw_next     = '0;
                halted_next = 1'b0;
            end
            else
            begin
                pos_next    = '0;
                bw_next     = bw_t;
                halted_next = halted_reg | bad_ab;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            held_reg   <= '{default: '0};
            bw_reg     <= '0;
            halted_reg <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            held_reg   <= held_next;
            bw_reg     <= bw_next;
            halted_reg <= halted_next;
        end
    end

endmodule

/* hdl/b64d_outbuf.sv */
// result buffer: takes up to three words of a group at once, hands them out
// one per cycle while result_ready is high; depends on b64d_pkg
module b64d_outbuf (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  b64d_pkg::group_res_t  load_res,
    output logic                  can_load,
    output logic                  result_valid,
    input  logic                  result_ready,
    output b64d_pkg::result_t     head_word
);

    b64d_pkg::result_t             entry_reg [b64d_pkg::NUM_SLOTS];
    b64d_pkg::result_t             entry_next [b64d_pkg::NUM_SLOTS];
    logic [b64d_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [b64d_pkg::CNT_W-1:0]    head_reg, head_next;
    logic                          take;

    assign result_valid = (cnt_reg != '0);
    assign head_word    = entry_reg[head_reg];
    assign take         = result_valid && result_ready;
    // free now, or the last word leaves this cycle
    assign can_load     = (cnt_reg == '0) ||
                          ((cnt_reg == b64d_pkg::CNT_W'(1)) && result_ready);

    always_comb
    begin
        entry_next = entry_reg;
        cnt_next   = cnt_reg;
        head_next  = head_reg;
        if (load)
        begin
            for (int i = 0; i < b64d_pkg::NUM_SLOTS; i++)
            begin
                entry_next[i] = load_res.slot[i];
            end
            cnt_next  = load_res.cnt;
            head_next = '0;
        end
        else if (take)
        begin
            cnt_next  = cnt_reg - b64d_pkg::CNT_W'(1);
            head_next = head_reg + b64d_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            head_reg <= '0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            head_reg <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

/* hdl/base64_stream_decoder_core.sv */
// base64 stream decoder top: input register, group decode, result buffer
// path: result words of a character pass the input register, then the result buffer
// throughput: one character per cycle; a completed group puts out one word per cycle
// if result_ready, and stalls input only while a group result finds the buffer busy
// reset: rst_n asynchronous active low, clears group state, counts and valid flags
// depends on b64d_pkg, b64d_group, b64d_outbuf
module base64_stream_decoder_core (
    input  logic        clk,
    input  logic        rst_n,
    // character channel
    input  logic        text_valid,
    output logic        text_ready,
    input  logic [7:0]  text_char,
    input  logic        end_of_text,
    // result channel
    output logic        result_valid,
    input  logic        result_ready,
    output logic [7:0]  out_byte,
    output logic [5:0]  out_index,
    output logic        byte_valid,
    output logic        string_done
);

    // input register: one character waiting for the group stage
    logic                  in_valid_reg, in_valid_next;
    logic [7:0]            char_reg;
    logic                  eot_reg;

    logic                  completes;
    logic                  can_load;
    logic                  step;
    logic                  load;
    b64d_pkg::group_res_t  grp_res;
    b64d_pkg::result_t     head_word;

    // a character that only fills the group never needs the buffer;
    // a completing character waits until the buffer can take its words
    assign step       = in_valid_reg && (!completes || can_load);
    assign load       = step && completes && (grp_res.cnt != '0);
    assign text_ready = !in_valid_reg || step;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (text_valid && text_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (text_valid && text_ready)
        begin
            char_reg <= text_char;
            eot_reg  <= end_of_text;
        end
    end

    b64d_group u_group (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .text_char   (char_reg),
        .end_of_text (eot_reg),
        .completes   (completes),
        .res         (grp_res)
    );

    b64d_outbuf u_outbuf (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (load),
        .load_res     (grp_res),
        .can_load     (can_load),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .head_word    (head_word)
    );

    assign out_byte    = head_word.data;
    assign out_index   = head_word.index;
    assign byte_valid  = head_word.bvalid;
    assign string_done = head_word.done;

endmodule

/* hdl/b64d_checker.sv */
// port-level checks for the base64 stream decoder, bound to the top level
// depends on base64_stream_decoder_core
module b64d_port_checks (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        text_ready,
    input  logic        result_valid,
    input  logic        result_ready,
    input  logic [7:0]  out_byte,
    input  logic [5:0]  out_index,
    input  logic        byte_valid,
    input  logic        string_done
);

    // no result offered while in reset
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !result_valid)
        else $error("result offered during reset");

    // stalled result word holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(out_byte) && $stable(out_index) &&
            $stable(byte_valid) && $stable(string_done))
        else $error("stalled result word changed");

    // a bare end marker is always the last word of a string and carries zeros
    a_bare_marker: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !byte_valid |-> string_done && out_byte == 8'd0 &&
            out_index == 6'd0)
        else $error("malformed end marker");

    // with the result side drained the decoder must take characters
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> text_ready)
        else $error("input stalled with empty result buffer");

endmodule

bind base64_stream_decoder_core b64d_port_checks u_b64d_port_checks (
    .clk          (clk),
    .rst_n        (rst_n),
    .text_ready   (text_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_byte     (out_byte),
    .out_index    (out_index),
    .byte_valid   (byte_valid),
    .string_done  (string_done)
);
